// ----- src/melody_note_sequencer_defines.svh -----
// Assertion macros used by the checker file.
`ifndef MELODY_NOTE_SEQUENCER_DEFINES_SVH
`define MELODY_NOTE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define MNS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mns check failed");

// Next-cycle implication, sampled on aclk, off while in reset.
`define MNS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mns check failed");

`endif

// ----- src/mns_pkg.sv -----
package mns_pkg;

    localparam int NOTE_ROM_DEPTH = 64;
    localparam int IDX_W = 7;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2
    } cmd_e;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  melody_group;
        logic [7:0]  variant_id;
        logic        force_play;
        logic [31:0] now_ms;
    } in_word_t;

    typedef struct packed {
        logic        tone_on;
        logic [11:0] tone_hz;
        logic        busy_res;
    } out_word_t;

    typedef struct packed {
        logic [11:0] hz;
        logic [8:0]  ms;
    } note_t;

    typedef struct packed {
        logic [5:0] base;
        logic [3:0] len;
    } mel_t;

    // v mod 3 by reciprocal multiply, exact for 8-bit v
    function automatic logic [1:0] mod3_u8(input logic [7:0] v);
        logic [15:0] p;
        logic [9:0]  t;
        p = 16'(v) * 16'd171;
        t = 10'(p[15:9]) * 10'd3;
        return 2'(10'(v) - t);
    endfunction

    function automatic mel_t mel_pick(input logic [2:0] grp, input logic [7:0] variant);
        logic [3:0] mel;
        mel_t       r;
        case (grp)
            3'd0:    mel = 4'(mod3_u8(variant));
            3'd1:    mel = 4'd3;
            3'd2:    mel = 4'd4;
            3'd3:    mel = 4'd5;
            3'd4:    mel = 4'd6 + 4'(variant[1:0]);
            3'd5:    mel = 4'd10 + 4'(mod3_u8(variant));
            default: mel = 4'd0;
        endcase
        case (mel)
            4'd0:    r = '{6'd0,  4'd3};
            4'd1:    r = '{6'd3,  4'd2};
            4'd2:    r = '{6'd5,  4'd3};
            4'd3:    r = '{6'd8,  4'd3};
            4'd4:    r = '{6'd11, 4'd1};
            4'd5:    r = '{6'd12, 4'd5};
            4'd6:    r = '{6'd17, 4'd11};
            4'd7:    r = '{6'd28, 4'd6};
            4'd8:    r = '{6'd34, 4'd5};
            4'd9:    r = '{6'd39, 4'd6};
            4'd10:   r = '{6'd45, 4'd3};
            4'd11:   r = '{6'd48, 4'd4};
            4'd12:   r = '{6'd52, 4'd5};
            default: r = '{6'd0,  4'd0};
        endcase
        return r;
    endfunction

    function automatic note_t note_lookup(input logic [IDX_W-1:0] idx);
        note_t r;
        case (idx)
            7'd0:    r = '{12'd988,  9'd65};
            7'd1:    r = '{12'd0,    9'd25};
            7'd2:    r = '{12'd1319, 9'd90};
            7'd3:    r = '{12'd1175, 9'd55};
            7'd4:    r = '{12'd1568, 9'd70};
            7'd5:    r = '{12'd659,  9'd60};
            7'd6:    r = '{12'd784,  9'd60};
            7'd7:    r = '{12'd988,  9'd85};
            7'd8:    r = '{12'd1760, 9'd45};
            7'd9:    r = '{12'd0,    9'd20};
            7'd10:   r = '{12'd2093, 9'd70};
            7'd11:   r = '{12'd1568, 9'd22};
            7'd12:   r = '{12'd784,  9'd48};
            7'd13:   r = '{12'd0,    9'd18};
            7'd14:   r = '{12'd1047, 9'd55};
            7'd15:   r = '{12'd0,    9'd18};
            7'd16:   r = '{12'd1568, 9'd95};
            7'd17:   r = '{12'd784,  9'd105};
            7'd18:   r = '{12'd988,  9'd105};
            7'd19:   r = '{12'd1175, 9'd125};
            7'd20:   r = '{12'd0,    9'd45};
            7'd21:   r = '{12'd988,  9'd90};
            7'd22:   r = '{12'd1175, 9'd90};
            7'd23:   r = '{12'd1568, 9'd220};
            7'd24:   r = '{12'd0,    9'd60};
            7'd25:   r = '{12'd1319, 9'd95};
            7'd26:   r = '{12'd1568, 9'd95};
            7'd27:   r = '{12'd1976, 9'd280};
            7'd28:   r = '{12'd523,  9'd90};
            7'd29:   r = '{12'd659,  9'd90};
            7'd30:   r = '{12'd784,  9'd90};
            7'd31:   r = '{12'd1047, 9'd180};
            7'd32:   r = '{12'd0,    9'd60};
            7'd33:   r = '{12'd1319, 9'd250};
            7'd34:   r = '{12'd988,  9'd70};
            7'd35:   r = '{12'd1175, 9'd70};
            7'd36:   r = '{12'd1319, 9'd70};
            7'd37:   r = '{12'd1568, 9'd70};
            7'd38:   r = '{12'd1976, 9'd230};
            7'd39:   r = '{12'd659,  9'd100};
            7'd40:   r = '{12'd0,    9'd40};
            7'd41:   r = '{12'd659,  9'd100};
            7'd42:   r = '{12'd0,    9'd40};
            7'd43:   r = '{12'd988,  9'd120};
            7'd44:   r = '{12'd1319, 9'd260};
            7'd45:   r = '{12'd659,  9'd110};
            7'd46:   r = '{12'd523,  9'd110};
            7'd47:   r = '{12'd392,  9'd210};
            7'd48:   r = '{12'd784,  9'd90};
            7'd49:   r = '{12'd659,  9'd90};
            7'd50:   r = '{12'd523,  9'd160};
            7'd51:   r = '{12'd392,  9'd220};
            7'd52:   r = '{12'd523,  9'd80};
            7'd53:   r = '{12'd0,    9'd30};
            7'd54:   r = '{12'd523,  9'd80};
            7'd55:   r = '{12'd0,    9'd30};
            7'd56:   r = '{12'd392,  9'd220};
            default: r = '{12'd0,    9'd0};
        endcase
        return r;
    endfunction

endpackage

// ----- src/mns_note_rom.sv -----
module mns_note_rom #(
    parameter int NOTE_ROM_DEPTH = mns_pkg::NOTE_ROM_DEPTH
) (
    input  logic                       aclk,
    input  logic [mns_pkg::IDX_W-1:0]  rd_addr,
    output mns_pkg::note_t             rd_data
);

    localparam logic [8:0] DEPTH_LIM = 9'(NOTE_ROM_DEPTH);

    mns_pkg::note_t data_reg;

    // entries past the depth read as a silent zero-length note
    always_ff @(posedge aclk) begin
        if (9'(rd_addr) < DEPTH_LIM) begin
            data_reg <= mns_pkg::note_lookup(rd_addr);
        end else begin
            data_reg <= '0;
        end
    end

    assign rd_data = data_reg;

endmodule

// ----- src/mns_seq_core.sv -----
module mns_seq_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_accept,
    input  mns_pkg::in_word_t          in_word,
    input  logic                       sound_enable_we,
    input  logic                       sound_enable_wdata,
    input  mns_pkg::note_t             rom_data,
    output logic [mns_pkg::IDX_W-1:0]  rom_addr,
    output mns_pkg::out_word_t         result
);

    logic        enable_reg,   enable_next;
    logic        playing_reg,  playing_next;
    logic        sounding_reg, sounding_next;
    logic [5:0]  base_reg,     base_next;
    logic [3:0]  len_reg,      len_next;
    logic [3:0]  pos_reg,      pos_next;
    logic [31:0] start_reg,    start_next;
    logic [11:0] freq_reg,     freq_next;

    logic [31:0]     elapsed;
    logic            halt;
    mns_pkg::mel_t   mel;

    assign elapsed = in_word.now_ms - start_reg;
    assign mel     = mns_pkg::mel_pick(in_word.melody_group, in_word.variant_id);

    always_comb begin
        enable_next   = enable_reg;
        playing_next  = playing_reg;
        sounding_next = sounding_reg;
        base_next     = base_reg;
        len_next      = len_reg;
        pos_next      = pos_reg;
        start_next    = start_reg;
        freq_next     = freq_reg;
        halt          = 1'b0;

        if (in_accept) begin
            case (in_word.cmd)
                mns_pkg::CMD_TICK: begin
                    if (playing_reg) begin
                        if (!sounding_reg) begin
                            if (pos_reg >= len_reg) begin
                                halt = 1'b1;
                            end else begin
                                freq_next     = rom_data.hz;
                                start_next    = in_word.now_ms;
                                sounding_next = 1'b1;
                            end
                        end else if (elapsed >= 32'(rom_data.ms)) begin
                            freq_next     = '0;
                            pos_next      = pos_reg + 4'd1;
                            sounding_next = 1'b0;
                        end
                    end
                end
                mns_pkg::CMD_START: begin
                    if ((in_word.melody_group inside {[3'd0:3'd5]}) &&
                        (enable_reg || in_word.force_play)) begin
                        freq_next     = '0;
                        base_next     = mel.base;
                        len_next      = mel.len;
                        pos_next      = '0;
                        playing_next  = 1'b1;
                        sounding_next = 1'b0;
                    end
                end
                mns_pkg::CMD_STOP: begin
                    halt = 1'b1;
                end
                default: begin
                end
            endcase
        end

        if (sound_enable_we) begin
            enable_next = sound_enable_wdata;
            if (!sound_enable_wdata) begin
                halt = 1'b1;
            end
        end

        // drop the tone and clear the sequence state, all but the note start time
        if (halt) begin
            freq_next     = '0;
            playing_next  = 1'b0;
            sounding_next = 1'b0;
            base_next     = '0;
            len_next      = '0;
            pos_next      = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg   <= 1'b1;
            playing_reg  <= 1'b0;
            sounding_reg <= 1'b0;
            base_reg     <= '0;
            len_reg      <= '0;
            pos_reg      <= '0;
            start_reg    <= '0;
            freq_reg     <= '0;
        end else begin
            enable_reg   <= enable_next;
            playing_reg  <= playing_next;
            sounding_reg <= sounding_next;
            base_reg     <= base_next;
            len_reg      <= len_next;
            pos_reg      <= pos_next;
            start_reg    <= start_next;
            freq_reg     <= freq_next;
        end
    end

    // prefetch the note at the next position so the ROM word is ready for the next tick
    assign rom_addr = aresetn ? (7'(base_next) + 7'(pos_next)) : '0;

    assign result.tone_on  = (freq_next != '0);
    assign result.tone_hz  = freq_next;
    assign result.busy_res = playing_next;

endmodule

// ----- src/mns_out_buf.sv -----
module mns_out_buf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  mns_pkg::out_word_t  push_data,
    output logic                full,
    output logic                m_valid,
    input  logic                m_ready,
    output mns_pkg::out_word_t  m_data
);

    logic [1:0]         count_reg, count_next;
    mns_pkg::out_word_t head_reg,  head_next;
    mns_pkg::out_word_t tail_reg,  tail_next;
    logic               pop;

    assign pop = m_valid && m_ready;

    always_comb begin
        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        case ({push, pop})
            2'b10: begin
                if (count_reg == 2'd0) begin
                    head_next = push_data;
                end else begin
                    tail_next = push_data;
                end
                count_next = count_reg + 2'd1;
            end
            2'b01: begin
                head_next  = tail_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11: begin
                if (count_reg == 2'd1) begin
                    head_next = push_data;
                end else begin
                    head_next = tail_reg;
                    tail_next = push_data;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign full    = (count_reg == 2'd2);
    assign m_valid = (count_reg != 2'd0);
    assign m_data  = head_reg;

endmodule

// ----- src/melody_note_sequencer.sv -----
// The result word is formed combinationally and pushed into the output buffer when its
// input word is accepted. One word per cycle while s_ready is high; the note ROM is read
// in the cycle before, at the next note index, so every tick finds its note registered.
// A two-word output buffer keeps input flowing while a result waits.
// Reset (aresetn low, synchronous): sequence stopped, tone silent, sound_enable set.
module melody_note_sequencer #(
    parameter int NOTE_ROM_DEPTH = mns_pkg::NOTE_ROM_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mns_pkg::in_word_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mns_pkg::out_word_t  m_data,
    input  logic                sound_enable_we,
    input  logic                sound_enable_wdata
);

    logic                       in_accept;
    logic                       buf_full;
    logic [mns_pkg::IDX_W-1:0]  rom_addr;
    mns_pkg::note_t             rom_data;
    mns_pkg::out_word_t         result;

    assign s_ready   = !buf_full;
    assign in_accept = s_valid && s_ready;

    mns_note_rom #(
        .NOTE_ROM_DEPTH(NOTE_ROM_DEPTH)
    ) u_rom (
        .aclk    (aclk),
        .rd_addr (rom_addr),
        .rd_data (rom_data)
    );

    mns_seq_core u_core (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .in_accept          (in_accept),
        .in_word            (s_data),
        .sound_enable_we    (sound_enable_we),
        .sound_enable_wdata (sound_enable_wdata),
        .rom_data           (rom_data),
        .rom_addr           (rom_addr),
        .result             (result)
    );

    mns_out_buf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_accept),
        .push_data (result),
        .full      (buf_full),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ----- src/mns_checker.sv -----
`include "melody_note_sequencer_defines.svh"

module mns_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input mns_pkg::out_word_t  m_data
);

    // hold a stalled result word
    `MNS_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    `MNS_ASSERT_SAME(a_tone_flag, m_valid, m_data.tone_on == (m_data.tone_hz != 12'd0))

    // a sounding tone only comes from a running sequence
    `MNS_ASSERT_SAME(a_tone_busy, m_valid && m_data.tone_on, m_data.busy_res)

    `MNS_ASSERT_SAME(a_reset_empty, $past(!aresetn), !m_valid && s_ready)

endmodule

bind melody_note_sequencer mns_checker u_mns_checker (.*);
